### design/lte_pkg.sv
// shared constants and types for the location table encoder
`timescale 1ns / 1ps

package lte_pkg;

  localparam int LINE_BITS = 20;
  localparam int COL_BITS  = 16;

  localparam int VAL_W = (LINE_BITS > COL_BITS) ? (LINE_BITS + 2) : (COL_BITS + 2);
  localparam int NFLD  = 4;
  localparam int FLD_W = $clog2(NFLD);
  localparam int NFLD_W = $clog2(NFLD + 1);

  localparam logic [3:0] CODE_NONE    = 4'd15;
  localparam logic [3:0] CODE_NOCOL   = 4'd13;
  localparam logic [3:0] CODE_LONG    = 4'd14;
  localparam logic [3:0] CODE_ONELINE = 4'd10;

  localparam logic [7:0] HDR_FLAG  = 8'h80;
  localparam logic [7:0] VINT_CONT = 8'h40;
  localparam logic [7:0] VINT_MASK = 8'h3F;
  localparam int         VINT_SHIFT = 6;

  localparam int SHORT_COL_LIM = 80;
  localparam int SHORT_W_LIM   = 16;
  localparam int ONE_COL_LIM   = 128;
  localparam int RUN_MAX       = 8;

  typedef logic signed [LINE_BITS:0] line_t;
  typedef logic signed [COL_BITS:0]  col_t;
  typedef logic [LINE_BITS-1:0]      line_u_t;

  typedef struct packed {
    line_t ls;
    line_t le;
    col_t  cs;
    col_t  ce;
  } loc_t;

  typedef struct packed {
    logic [7:0]                   hdr;
    logic                         raw;
    logic [NFLD_W-1:0]            nfld;
    logic [NFLD-1:0][VAL_W-1:0]   vals;
    logic                         last;
  } entry_t;

endpackage

### design/lte_chan_if.sv
// valid/ready channel interfaces for instruction locations and table bytes
`timescale 1ns / 1ps

interface lte_in_if;
  import lte_pkg::*;

  logic  valid;
  logic  ready;
  line_t line_start;
  line_t line_end;
  col_t  col_start;
  col_t  col_end;
  logic  final_instr;

  modport source (output valid, output line_start, output line_end, output col_start,
                  output col_end, output final_instr, input ready);
  modport sink (input valid, input line_start, input line_end, input col_start,
                input col_end, input final_instr, output ready);
endinterface

interface lte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

### design/lte_front.sv
// run tracking and entry selection, holds up to two entries per beat
`timescale 1ns / 1ps

module lte_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  lte_pkg::line_u_t  cfg_wr_data,
  lte_in_if.sink            in_chan,
  output logic              desc_valid,
  output lte_pkg::entry_t   desc,
  input  logic              desc_ready
);
  import lte_pkg::*;

  typedef struct packed {
    entry_t e;
    logic   upd;
  } enc_t;

  function automatic enc_t encode(loc_t r, logic [2:0] lb, line_u_t cl);
    enc_t res;
    logic signed [LINE_BITS+1:0] d;
    logic signed [LINE_BITS+1:0] nd;
    logic signed [LINE_BITS+1:0] ed;
    logic [LINE_BITS-1:0] mag;
    logic [VAL_W-1:0] zz;
    logic [COL_BITS+1:0] cs1;
    logic [COL_BITS+1:0] ce1;
    logic signed [COL_BITS+1:0] wd;
    logic same_ln;
    logic le_none;
    logic [3:0] code;
    d   = $signed({r.ls[LINE_BITS], r.ls}) - $signed({2'b00, cl});
    nd  = -d;
    mag = d[LINE_BITS+1] ? nd[LINE_BITS-1:0] : d[LINE_BITS-1:0];
    zz  = {{(VAL_W-LINE_BITS-1){1'b0}}, mag, d[LINE_BITS+1]};
    ed  = $signed({r.le[LINE_BITS], r.le}) - $signed({r.ls[LINE_BITS], r.ls});
    cs1 = {r.cs[COL_BITS], r.cs} + (COL_BITS+2)'(1);
    ce1 = {r.ce[COL_BITS], r.ce} + (COL_BITS+2)'(1);
    wd  = $signed({r.ce[COL_BITS], r.ce}) - $signed({r.cs[COL_BITS], r.cs});
    same_ln = (r.le == r.ls);
    le_none = (r.le == '1);
    code         = CODE_LONG;
    res.e.raw    = 1'b0;
    res.e.nfld   = NFLD_W'(NFLD);
    res.e.vals   = '0;
    res.e.vals[0] = zz;
    res.e.vals[1] = VAL_W'($unsigned(ed));
    res.e.vals[2] = VAL_W'(cs1);
    res.e.vals[3] = VAL_W'(ce1);
    res.e.last   = 1'b0;
    res.upd      = 1'b1;
    if (r.ls[LINE_BITS]) begin
      code       = CODE_NONE;
      res.e.nfld = '0;
      res.upd    = 1'b0;
    end else if (r.cs[COL_BITS] || r.ce[COL_BITS]) begin
      if (same_ln || le_none) begin
        code       = CODE_NOCOL;
        res.e.nfld = NFLD_W'(1);
      end
    end else if (same_ln) begin
      if (d == 0 && $signed(r.cs) < SHORT_COL_LIM && !wd[COL_BITS+1] &&
          $signed(wd) < SHORT_W_LIM) begin
        code          = r.cs[6:3];
        res.e.raw     = 1'b1;
        res.e.nfld    = NFLD_W'(1);
        res.e.vals[0] = VAL_W'({1'b0, r.cs[2:0], wd[3:0]});
        res.upd       = 1'b0;
      end else if (!d[LINE_BITS+1] && d <= 2 && $signed(r.cs) < ONE_COL_LIM &&
                   $signed(r.ce) < ONE_COL_LIM) begin
        code          = CODE_ONELINE + d[3:0];
        res.e.raw     = 1'b1;
        res.e.nfld    = NFLD_W'(2);
        res.e.vals[0] = VAL_W'(r.cs[6:0]);
        res.e.vals[1] = VAL_W'(r.ce[6:0]);
      end
    end
    res.e.hdr = HDR_FLAG | {1'b0, code, lb};
    return res;
  endfunction

  loc_t    run_r;
  logic [3:0] run_len_r;
  line_u_t cl_r;
  line_u_t first_line_r;
  entry_t  sa_r;
  entry_t  sb_r;
  logic    sa_v_r;
  logic    sb_v_r;

  loc_t    x;
  loc_t    run_nxt;
  logic [3:0] run_len_nxt;
  logic [3:0] lm1_a;
  logic [3:0] lm1_b;
  logic    has_run;
  logic    flush;
  logic    fin;
  logic    accept;
  logic    pop;
  enc_t    enc_a;
  enc_t    enc_b;
  line_u_t cl_a;
  entry_t  ent_a;
  entry_t  ent_b;

  always_comb begin
    x.ls = in_chan.line_start;
    x.le = in_chan.line_end;
    x.cs = in_chan.col_start;
    x.ce = in_chan.col_end;
    fin  = in_chan.final_instr;
    has_run = (run_len_r != 4'd0);
    flush   = has_run && ((x != run_r) || (run_len_r >= 4'(RUN_MAX)));
    lm1_a   = run_len_r - 4'd1;
    enc_a   = encode(run_r, lm1_a[2:0], cl_r);
    cl_a    = (flush && enc_a.upd) ? run_r.ls[LINE_BITS-1:0] : cl_r;
    if (flush || !has_run) begin
      run_nxt     = x;
      run_len_nxt = 4'd1;
    end else begin
      run_nxt     = run_r;
      run_len_nxt = run_len_r + 4'd1;
    end
    lm1_b = run_len_nxt - 4'd1;
    enc_b = encode(run_nxt, lm1_b[2:0], cl_a);
    ent_a = enc_a.e;
    ent_a.last = !fin;
    ent_b = enc_b.e;
    ent_b.last = 1'b1;
  end

  assign desc_valid    = sa_v_r || sb_v_r;
  assign desc          = sa_v_r ? sa_r : sb_r;
  assign pop           = desc_valid && desc_ready;
  assign in_chan.ready = rst_n && (!desc_valid || (pop && !(sa_v_r && sb_v_r)));
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_len_r    <= 4'd0;
      cl_r         <= line_u_t'(1);
      first_line_r <= line_u_t'(1);
      sa_v_r       <= 1'b0;
      sb_v_r       <= 1'b0;
    end else begin
      if (accept) begin
        run_r     <= run_nxt;
        run_len_r <= fin ? 4'd0 : run_len_nxt;
        cl_r      <= fin ? first_line_r : cl_a;
        sa_r      <= flush ? ent_a : ent_b;
        sa_v_r    <= flush || fin;
        sb_r      <= ent_b;
        sb_v_r    <= flush && fin;
      end else if (pop) begin
        if (sa_v_r) begin
          sa_v_r <= 1'b0;
        end else begin
          sb_v_r <= 1'b0;
        end
      end
      if (cfg_wr_en) begin
        first_line_r <= cfg_wr_data;
        cl_r         <= cfg_wr_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    sa_v_r && sb_v_r |-> !in_chan.ready)
    else $error("input taken while both entry slots are full");
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    run_len_r <= 4'(RUN_MAX))
    else $error("run longer than allowed");
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && fin |=> run_len_r == 4'd0 && sa_v_r)
    else $error("final beat left a pending run");
`endif

endmodule

### design/lte_ser.sv
// byte serializer: header, raw bytes and 6-bit varints per entry
`timescale 1ns / 1ps

module lte_ser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            desc_valid,
  input  lte_pkg::entry_t desc,
  output logic            desc_ready,
  lte_out_if.source       out_chan
);
  import lte_pkg::*;

  logic                       busy_r;
  logic                       hdr_ph_r;
  logic [7:0]                 hdr_r;
  logic                       raw_r;
  logic                       nofld_r;
  logic [FLD_W-1:0]           lastf_r;
  logic [FLD_W-1:0]           fld_r;
  logic [NFLD-1:0][VAL_W-1:0] vals_r;
  logic [VAL_W-1:0]           res_r;
  logic                       last_r;
  logic                       out_v_r;
  logic [7:0]                 out_byte_r;
  logic                       out_last_r;

  logic [NFLD_W-1:0] nfld_m1;
  logic [FLD_W-1:0]  fld_nxt;
  logic              fdone;
  logic              edone;
  logic              emit;
  logic [7:0]        byte_cur;

  always_comb begin
    fdone = raw_r || (res_r[VAL_W-1:VINT_SHIFT] == '0);
    if (hdr_ph_r) begin
      byte_cur = hdr_r;
      edone    = nofld_r;
    end else begin
      byte_cur = fdone ? res_r[7:0] : ((res_r[7:0] & VINT_MASK) | VINT_CONT);
      edone    = fdone && (fld_r == lastf_r);
    end
    nfld_m1 = desc.nfld - NFLD_W'(1);
    fld_nxt = fld_r + FLD_W'(1);
  end

  assign emit       = busy_r && (!out_v_r || out_chan.ready);
  assign desc_ready = !busy_r || (emit && edone);

  assign out_chan.valid     = out_v_r;
  assign out_chan.out_byte  = out_byte_r;
  assign out_chan.last_byte = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (emit) begin
        out_v_r    <= 1'b1;
        out_byte_r <= byte_cur;
        out_last_r <= edone && last_r;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
      if (desc_valid && desc_ready) begin
        busy_r   <= 1'b1;
        hdr_ph_r <= 1'b1;
        hdr_r    <= desc.hdr;
        raw_r    <= desc.raw;
        nofld_r  <= (desc.nfld == '0);
        lastf_r  <= nfld_m1[FLD_W-1:0];
        fld_r    <= '0;
        vals_r   <= desc.vals;
        res_r    <= desc.vals[0];
        last_r   <= desc.last;
      end else if (emit) begin
        if (edone) begin
          busy_r <= 1'b0;
        end else if (hdr_ph_r) begin
          hdr_ph_r <= 1'b0;
        end else if (fdone) begin
          fld_r <= fld_nxt;
          res_r <= vals_r[fld_nxt];
        end else begin
          res_r <= res_r >> VINT_SHIFT;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_load_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    desc_valid && desc_ready |=> busy_r && hdr_ph_r)
    else $error("entry load did not start with its header");
  a_fld_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !hdr_ph_r |-> !nofld_r && fld_r <= lastf_r)
    else $error("field index past the last field");
  a_cont_more: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !hdr_ph_r && !fdone |=> busy_r && !hdr_ph_r)
    else $error("continuation byte ended its entry");
`endif

endmodule

### design/location_table_encoder_core.sv
// location table encoder top level: run tracker feeding a byte serializer
//
//   channel   dir  beat                                         handshake
//   in_chan   in   line_start, line_end, col_start, col_end,    valid/ready
//                  final_instr
//   out_chan  out  out_byte, last_byte                          valid/ready
//   cfg_*     in   first_line                                   cfg_wr_en
//
// one input beat is taken per cycle while entry slots are free; a beat closes
// at most two entries, held until the serializer takes them
// output runs at one byte per cycle while out_chan is ready; an item that closes entries
// causes as many bytes as those entries hold (up to 30, typically
// two or three per run)
// reset clears the run and loads first_line with 1; no clearing pass
// a stalled out_chan backs up into the serializer, then the slots, then in_chan
`timescale 1ns / 1ps

module location_table_encoder_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  lte_pkg::line_u_t cfg_wr_data,
  lte_in_if.sink           in_chan,
  lte_out_if.source        out_chan
);
  import lte_pkg::*;

  logic   desc_valid;
  logic   desc_ready;
  entry_t desc;

  lte_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_chan    (in_chan),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_ready (desc_ready)
  );

  lte_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .desc_valid(desc_valid),
    .desc      (desc),
    .desc_ready(desc_ready),
    .out_chan  (out_chan)
  );

endmodule

### tb/tb_location_table_encoder_core.sv
// self-checking testbench for location_table_encoder_core: random runs, stalls, byte-level checks
`timescale 1ns / 1ps

module tb_location_table_encoder_core;
  import lte_pkg::*;

  localparam int       NUM_PHASES     = 6;
  localparam int       RANDOM_PER_PH  = 95;
  localparam int       DRAIN_CYCLES   = 40;
  localparam int       MAX_STEP_BYTES = 30;
  localparam int       LINE_TOP       = (1 << LINE_BITS) - 1;
  localparam int       COL_TOP        = (1 << COL_BITS) - 1;

  typedef longint unsigned u64_t;

  localparam u64_t LINE_WRAP = (64'd1 << (LINE_BITS + 2)) - 1;
  localparam u64_t COL_WRAP  = (64'd1 << (COL_BITS + 2)) - 1;

  typedef struct {
    loc_t loc;
    logic fin;
  } instr_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } table_byte_t;

  typedef enum int {
    KIND_NONE,
    KIND_NOCOL,
    KIND_SHORT,
    KIND_ONELINE,
    KIND_LONG,
    KIND_COUNT
  } entry_kind_e;

  logic     clk;
  logic     rst_n;
  logic     cfg_wr_en;
  line_u_t  cfg_wr_data;

  lte_in_if  in_if ();
  lte_out_if out_if ();

  location_table_encoder_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_if),
    .out_chan    (out_if)
  );

  always #10 clk = ~clk;

  instr_t      pending_locs[$];
  table_byte_t table_bytes_due[$];
  instr_t      beat_in_flight;

  // encoder state as the block should hold it
  line_u_t first_line_reg;
  longint  run_ls;
  longint  run_le;
  longint  run_cs;
  longint  run_ce;
  int      run_len;
  longint  pred_line;
  int      step_bytes;

  int in_idle_pct;
  int out_idle_pct;
  int in_hold;
  int out_hold;
  int mismatches;
  int locs_accepted;
  int bytes_checked;
  int kind_seen[KIND_COUNT];

  function automatic void push_table_byte(logic [7:0] b);
    table_byte_t tb_entry;
    if (step_bytes < MAX_STEP_BYTES) begin
      tb_entry.data = b;
      tb_entry.last = 1'b0;
      table_bytes_due.insert(table_bytes_due.size(), tb_entry);
    end
    step_bytes++;
  endfunction

  function automatic logic [7:0] entry_header(logic [3:0] code, logic [2:0] run_bits);
    return HDR_FLAG | {1'b0, code, run_bits};
  endfunction

  function automatic void push_varint(u64_t v);
    while (v > u64_t'(VINT_MASK)) begin
      push_table_byte((8'(v) & VINT_MASK) | VINT_CONT);
      v = v >> VINT_SHIFT;
    end
    push_table_byte(8'(v));
  endfunction

  function automatic void push_zigzag(longint d);
    if (d < 0) begin
      push_varint((u64_t'(-d) << 1) | 64'd1);
    end else begin
      push_varint(u64_t'(d) << 1);
    end
  endfunction

  function automatic void emit_entry();
    logic [2:0] run_bits;
    longint     delta;
    run_bits = 3'(run_len - 1);
    delta    = run_ls - pred_line;
    if (run_ls < 0) begin
      push_table_byte(entry_header(CODE_NONE, run_bits));
      kind_seen[KIND_NONE]++;
      return;
    end
    if (run_cs < 0 || run_ce < 0) begin
      if (run_le == run_ls || run_le == -1) begin
        push_table_byte(entry_header(CODE_NOCOL, run_bits));
        push_zigzag(delta);
        pred_line = run_ls;
        kind_seen[KIND_NOCOL]++;
        return;
      end
    end else if (run_le == run_ls) begin
      if (delta == 0 && run_cs < SHORT_COL_LIM && run_ce >= run_cs &&
          run_ce - run_cs < SHORT_W_LIM) begin
        push_table_byte(entry_header(4'(run_cs >> 3), run_bits));
        push_table_byte({1'b0, 3'(run_cs), 4'(run_ce - run_cs)});
        kind_seen[KIND_SHORT]++;
        return;
      end
      if (delta >= 0 && delta <= 2 && run_cs < ONE_COL_LIM && run_ce < ONE_COL_LIM) begin
        push_table_byte(entry_header(CODE_ONELINE + 4'(delta), run_bits));
        push_table_byte(8'(run_cs));
        push_table_byte(8'(run_ce));
        pred_line = run_ls;
        kind_seen[KIND_ONELINE]++;
        return;
      end
    end
    push_table_byte(entry_header(CODE_LONG, run_bits));
    push_zigzag(delta);
    push_varint(u64_t'(run_le - run_ls) & LINE_WRAP);
    push_varint(u64_t'(run_cs + 1) & COL_WRAP);
    push_varint(u64_t'(run_ce + 1) & COL_WRAP);
    pred_line = run_ls;
    kind_seen[KIND_LONG]++;
  endfunction

  // bytes that one accepted location should produce
  function automatic void encode_location(instr_t it);
    longint ls;
    longint le;
    longint cs;
    longint ce;
    int     first;
    ls = it.loc.ls;
    le = it.loc.le;
    cs = it.loc.cs;
    ce = it.loc.ce;
    step_bytes = 0;
    first = table_bytes_due.size();
    if (run_len > 0) begin
      if (ls != run_ls || le != run_le || cs != run_cs || ce != run_ce ||
          run_len >= RUN_MAX) begin
        emit_entry();
        run_len = 0;
      end
    end
    if (run_len == 0) begin
      run_ls  = ls;
      run_le  = le;
      run_cs  = cs;
      run_ce  = ce;
      run_len = 1;
    end else begin
      run_len++;
    end
    if (it.fin) begin
      emit_entry();
      run_len = 0;
      pred_line = first_line_reg;
    end
    if (table_bytes_due.size() > first) begin
      table_bytes_due[table_bytes_due.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void add_loc(int ls, int le, int cs, int ce, bit fin);
    instr_t it;
    it.loc.ls = line_t'(ls);
    it.loc.le = line_t'(le);
    it.loc.cs = col_t'(cs);
    it.loc.ce = col_t'(ce);
    it.fin    = fin;
    pending_locs.insert(pending_locs.size(), it);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_hold = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        encode_location(beat_in_flight);
        locs_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_hold > 0) begin
          in_hold--;
          in_if.valid <= 1'b0;
        end else if (pending_locs.size() != 0 && $urandom_range(0, 99) < in_idle_pct) begin
          in_hold = $urandom_range(0, 17);
          in_if.valid <= 1'b0;
        end else if (pending_locs.size() != 0) begin
          beat_in_flight = pending_locs.pop_front();
          in_if.line_start  <= beat_in_flight.loc.ls;
          in_if.line_end    <= beat_in_flight.loc.le;
          in_if.col_start   <= beat_in_flight.loc.cs;
          in_if.col_end     <= beat_in_flight.loc.ce;
          in_if.final_instr <= beat_in_flight.fin;
          in_if.valid       <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin : monitor
    table_byte_t due;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (table_bytes_due.size() == 0) begin
          $error("out_byte: expected no beat, got %02h", out_if.out_byte);
          mismatches++;
        end else begin
          due = table_bytes_due.pop_front();
          if (out_if.out_byte !== due.data) begin
            $error("out_byte: expected %02h, got %02h", due.data, out_if.out_byte);
            mismatches++;
          end
          if (out_if.last_byte !== due.last) begin
            $error("last_byte: expected %0b, got %0b", due.last, out_if.last_byte);
            mismatches++;
          end
          bytes_checked++;
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < out_idle_pct) begin
        out_hold = $urandom_range(0, 17);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int      added;
    int      reps;
    int      pick;
    int      gen_line;
    int      ls;
    int      le;
    int      cs;
    int      ce;
    line_u_t new_first;

    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_if.valid       = 1'b0;
    in_if.line_start  = '0;
    in_if.line_end    = '0;
    in_if.col_start   = '0;
    in_if.col_end     = '0;
    in_if.final_instr = 1'b0;
    out_if.ready      = 1'b0;
    first_line_reg    = 1;
    pred_line         = 1;
    run_ls            = 0;
    run_le            = 0;
    run_cs            = 0;
    run_ce            = 0;
    run_len           = 0;
    mismatches        = 0;
    locs_accepted     = 0;
    bytes_checked     = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        case (phase)
          1: new_first = '0;
          2: new_first = line_u_t'(LINE_TOP);
          3: new_first = line_u_t'($urandom);
          4: new_first = 1;
          default: new_first = line_u_t'($urandom_range(0, 300));
        endcase
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= new_first;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        first_line_reg = new_first;
        pred_line      = new_first;
      end

      case (phase)
        0: begin in_idle_pct = 15; out_idle_pct = 8;  end
        1: begin in_idle_pct = 25; out_idle_pct = 3;  end
        2: begin in_idle_pct = 5;  out_idle_pct = 10; end
        3: begin in_idle_pct = 10; out_idle_pct = 6;  end
        4: begin in_idle_pct = 20; out_idle_pct = 12; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase

      @(negedge clk);
      if (phase == 0) begin
        // short form, width limits, one-line deltas, long, none, no-columns
        add_loc(1, 1, 5, 10, 1'b0);
        add_loc(1, 1, 5, 10, 1'b0);
        add_loc(1, 1, 79, 94, 1'b0);
        add_loc(2, 2, 0, 0, 1'b0);
        add_loc(4, 4, 127, 127, 1'b0);
        add_loc(4, 4, 80, 80, 1'b0);
        add_loc(4, 4, 10, 5, 1'b0);
        add_loc(4, 4, 128, 0, 1'b0);
        add_loc(-1, -1, -1, -1, 1'b0);
        add_loc(LINE_TOP, LINE_TOP, -1, 3, 1'b0);
        add_loc(100, -1, 3, -1, 1'b1);
        add_loc(100, 50, COL_TOP, COL_TOP, 1'b0);
        add_loc(0, LINE_TOP, -1, -1, 1'b0);
        add_loc(-(LINE_TOP + 1), 0, -(COL_TOP + 1), -2, 1'b0);
        add_loc(5, 5, -(COL_TOP + 1), 7, 1'b0);
        add_loc(5, 9, -3, -(COL_TOP + 1), 1'b0);
        // run longer than a full entry, closed by the final instruction
        repeat (8) add_loc(6, 6, 1, 2, 1'b0);
        add_loc(6, 6, 1, 2, 1'b1);
      end else begin
        added    = 0;
        gen_line = first_line_reg;
        while (added < RANDOM_PER_PH) begin
          pick = $urandom_range(0, 9);
          if (pick < 6) gen_line += $urandom_range(0, 2);
          else if (pick < 8) gen_line -= $urandom_range(1, 3);
          else if (pick == 8) gen_line = $urandom_range(0, LINE_TOP);
          else gen_line += $urandom_range(3, 200);
          if (gen_line < 0) gen_line = 0;
          if (gen_line > LINE_TOP) gen_line = LINE_TOP;

          ls   = gen_line;
          le   = ls;
          cs   = $urandom_range(0, 85);
          ce   = cs + $urandom_range(0, 17);
          pick = $urandom_range(0, 99);
          if (pick < 30) begin
            if ($urandom_range(0, 3) == 0) ce = cs - $urandom_range(1, 4);
          end else if (pick < 48) begin
            cs = $urandom_range(0, 130);
            ce = $urandom_range(0, 130);
          end else if (pick < 64) begin
            le = $urandom_range(0, 1) ? ls + $urandom_range(0, 4) : $urandom_range(0, LINE_TOP);
            cs = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom_range(0, COL_TOP);
            ce = $urandom_range(0, COL_TOP);
          end else if (pick < 74) begin
            case ($urandom_range(0, 3))
              0: cs = -1;
              1: ce = -1;
              2: begin cs = -1; ce = -1; end
              default: cs = -$urandom_range(2, COL_TOP + 1);
            endcase
            case ($urandom_range(0, 3))
              0: le = -1;
              1: le = ls + 1;
              default: le = ls;
            endcase
          end else if (pick < 82) begin
            ls = $urandom_range(0, 3) == 0 ? -$urandom_range(2, LINE_TOP + 1) : -1;
            le = $urandom_range(0, 1) ? -1 : $urandom_range(0, LINE_TOP);
          end else begin
            ls = $urandom;
            le = $urandom;
            cs = $urandom;
            ce = $urandom;
          end

          reps = $urandom_range(0, 3) == 0 ? $urandom_range(6, 17) : $urandom_range(1, 3);
          if (reps > RANDOM_PER_PH - added) reps = RANDOM_PER_PH - added;
          repeat (reps) add_loc(ls, le, cs, ce, 1'b0);
          added += reps;
          if ($urandom_range(0, 11) == 0) begin
            pending_locs[pending_locs.size() - 1].fin = 1'b1;
          end
        end
        // each phase closes its table so no run is left open across a write
        pending_locs[pending_locs.size() - 1].fin = 1'b1;
      end

      do @(negedge clk);
      while (pending_locs.size() != 0 || in_if.valid || table_bytes_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clk);
    end

    $display("Run covered %0d locations over %0d first_line settings, %0d bytes checked",
             locs_accepted, NUM_PHASES, bytes_checked);
    $display("Entries: none %0d, no-columns %0d, short %0d, one-line %0d, long %0d",
             kind_seen[KIND_NONE], kind_seen[KIND_NOCOL], kind_seen[KIND_SHORT],
             kind_seen[KIND_ONELINE], kind_seen[KIND_LONG]);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
